/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/gsad_pkg.sv */
// Shared constants and control/status types for the gated sample averager.
// No dependencies.
`default_nettype none
package gsad_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int SUM_BITS     = 26;
  localparam int HOLE_BITS    = 17;
  localparam int SCALE        = 100;
  localparam int SCALE_BITS   = 7;
  localparam int PROD_BITS    = SUM_BITS + SCALE_BITS;
  localparam logic [HOLE_BITS-1:0] THRESH_RESET = HOLE_BITS'(100);

  typedef struct packed {
    logic accept;
    logic div_start;
    logic fin;
  } gsad_cmd_t;

  typedef struct packed {
    logic close;
    logic res_busy;
    logic div_done;
  } gsad_stat_t;

endpackage
`default_nettype wire

/* hdl/gsad_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on gsad_pkg.
`default_nettype none
module gsad_div #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gsad_pkg::PROD_BITS-1:0] dividend,
  input  logic [COUNT_BITS-1:0]          divisor,
  output logic                           done,
  output logic [gsad_pkg::PROD_BITS-1:0] quotient
);
  import gsad_pkg::*;

  localparam int STEP_BITS = $clog2(PROD_BITS + 1);

  logic [STEP_BITS-1:0]  steps;
  logic [COUNT_BITS-1:0] rem;
  logic [PROD_BITS-1:0]  quo;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  always_comb begin
    trial = {rem, quo[PROD_BITS-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_BITS'(1));
      if (start) begin
        steps <= STEP_BITS'(PROD_BITS);
      end else if (steps != '0) begin
        steps <= steps - STEP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (steps != '0) begin
      rem <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo <= {quo[PROD_BITS-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

/* hdl/gsad_ctrl.sv */
// Controller: input handshake and sequencing of the window-close division.
// Depends on gsad_pkg.
`default_nettype none
module gsad_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gsad_pkg::gsad_stat_t stat,
  output gsad_pkg::gsad_cmd_t  cmd
);
  import gsad_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_FIN} state_t;

  state_t state;
  logic   div_start;
  logic   fin;

  assign in_ready      = (state == S_IDLE) && !stat.res_busy;
  assign cmd.accept    = in_valid && in_ready;
  assign cmd.div_start = div_start;
  assign cmd.fin       = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      fin       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      fin       <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.accept && stat.close) begin
            state     <= S_WAIT;
            div_start <= 1'b1;
          end
        end
        S_WAIT: begin
          if (stat.div_done) begin
            state <= S_FIN;
            fin   <= 1'b1;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/gsad_dp.sv */
// Datapath: threshold, window accumulators, divider, result and output words.
// Depends on gsad_pkg and gsad_div.
`default_nettype none
module gsad_dp #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [gsad_pkg::HOLE_BITS-1:0] cfg_wr_data,
  input  logic                           object_present,
  input  logic [gsad_pkg::SAMPLE_W-1:0]  sample,
  input  gsad_pkg::gsad_cmd_t            cmd,
  output gsad_pkg::gsad_stat_t           stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           gate_on,
  output logic                           window_done,
  output logic [gsad_pkg::HOLE_BITS-1:0] hole_size,
  output logic                           defect
);
  import gsad_pkg::*;

  localparam int USE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [HOLE_BITS-1:0]  threshold;
  logic                  active;
  logic [SUM_BITS-1:0]   sum;
  logic [COUNT_BITS-1:0] count;
  logic                  latch;

  logic [SUM_BITS-1:0]   smp;
  logic                  opening;
  logic                  counting;
  logic                  closing;
  logic [SUM_BITS-1:0]   base_sum;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [SUM_BITS:0]     sum_add;
  logic [SUM_BITS-1:0]   sum_next;
  logic [COUNT_BITS-1:0] count_next;

  logic [PROD_BITS-1:0]  product;
  logic [PROD_BITS-1:0]  quotient;
  logic [PROD_BITS-1:0]  q_eff;
  logic                  div_done;
  logic                  over;
  logic [HOLE_BITS-1:0]  hole_sat;

  logic                  res_valid;
  logic                  res_gate;
  logic                  res_done;
  logic [HOLE_BITS-1:0]  res_hole;
  logic                  res_defect;

  always_comb begin
    smp        = {{(SUM_BITS-USE_BITS){1'b0}}, sample[USE_BITS-1:0]};
    opening    = !active && object_present;
    counting   = active || object_present;
    closing    = active && !object_present;
    base_sum   = opening ? '0 : sum;
    base_cnt   = opening ? '0 : count;
    sum_add    = {1'b0, base_sum} + {1'b0, smp};
    sum_next   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
    count_next = (base_cnt == '1) ? base_cnt : base_cnt + COUNT_BITS'(1);
    product    = {{SCALE_BITS{1'b0}}, sum} * PROD_BITS'(SCALE);
    q_eff      = (count == '0) ? '0 : quotient;
    over       = q_eff > {{(PROD_BITS-HOLE_BITS){1'b0}}, threshold};
    hole_sat   = (q_eff[PROD_BITS-1:HOLE_BITS] != '0) ? '1 : q_eff[HOLE_BITS-1:0];
  end

  assign stat.close    = closing;
  assign stat.res_busy = res_valid;
  assign stat.div_done = div_done;

  gsad_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      active    <= 1'b0;
      sum       <= '0;
      count     <= '0;
      latch     <= 1'b0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (counting) begin
          sum   <= sum_next;
          count <= count_next;
        end
        if (opening) begin
          active <= 1'b1;
          latch  <= 1'b0;
        end
        if (closing) begin
          active <= 1'b0;
        end else begin
          res_valid  <= 1'b1;
          res_gate   <= counting;
          res_done   <= 1'b0;
          res_hole   <= '0;
          res_defect <= opening ? 1'b0 : latch;
        end
      end
      if (cmd.fin) begin
        latch      <= over;
        res_valid  <= 1'b1;
        res_gate   <= 1'b0;
        res_done   <= 1'b1;
        res_hole   <= hole_sat;
        res_defect <= over;
      end
      // move the pending word into the output register
      if (res_valid && (!out_valid || out_ready)) begin
        res_valid   <= 1'b0;
        out_valid   <= 1'b1;
        gate_on     <= res_gate;
        window_done <= res_done;
        hole_size   <= res_hole;
        defect      <= res_defect;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/gated_sample_average_defect_core.sv */
// Ordinary tick: word via result to output register, next word taken after that.
// Closing tick: the output word waits for the 33-step serial divider.
// One result register plus one output register part the input and output sides.
// Reset (rst, synchronous): window closed, sum, count and defect cleared,
// threshold back to 100. No clearing pass.
`default_nettype none
module gated_sample_average_defect_core #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [gsad_pkg::HOLE_BITS-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           object_present,
  input  logic [gsad_pkg::SAMPLE_W-1:0]  sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           gate_on,
  output logic                           window_done,
  output logic [gsad_pkg::HOLE_BITS-1:0] hole_size,
  output logic                           defect
);
  import gsad_pkg::*;

  gsad_cmd_t  cmd;
  gsad_stat_t stat;

  gsad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gsad_dp #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .object_present (object_present),
    .sample         (sample),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .gate_on        (gate_on),
    .window_done    (window_done),
    .hole_size      (hole_size),
    .defect         (defect)
  );

endmodule
`default_nettype wire

/* hdl/gsad_checker.sv */
// Port-level checks on the output words of the averager core, with its bind.
// Depends on gsad_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module gsad_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           gate_on,
  input logic                           window_done,
  input logic [gsad_pkg::HOLE_BITS-1:0] hole_size,
  input logic                           defect
);
  import gsad_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(hole_size))
  `ASSERT_IMPL(a_done_gate, clk, rst, out_valid && window_done, !gate_on)
  `ASSERT_IMPL(a_hole_zero, clk, rst, out_valid && !window_done, hole_size == '0)
  `ASSERT_IMPL(a_open_clean, clk, rst, out_valid && gate_on, !defect)

endmodule

bind gated_sample_average_defect_core gsad_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .gate_on     (gate_on),
  .window_done (window_done),
  .hole_size   (hole_size),
  .defect      (defect)
);
`default_nettype wire

/* test/tb.sv */
// Testbench for gated_sample_average_defect_core: a directed table, then random windows.
// Each word is predicted by a bench averager model or the table, checked field by field.
// Depends on gsad_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import gsad_pkg::*;

  localparam int COUNT_W        = 16;
  localparam longint unsigned SUM_MAX  = (64'd1 << SUM_BITS) - 1;
  localparam longint unsigned HOLE_MAX = (64'd1 << HOLE_BITS) - 1;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 240;

  typedef struct packed {
    logic                 gate;
    logic                 done;
    logic [HOLE_BITS-1:0] hole;
    logic                 dfct;
  } tick_result_t;

  typedef enum {ROW_TICK, ROW_THRESH} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 present;
    logic [SAMPLE_W-1:0]  smp;
    int                   reps;
    logic [HOLE_BITS-1:0] value;
    bit                   typed;
    tick_result_t         want;
  } stim_row_t;

  logic                 clk;
  logic                 rst            = 1'b1;
  logic                 cfg_wr_en      = 1'b0;
  logic [HOLE_BITS-1:0] cfg_wr_data    = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic                 object_present = 1'b0;
  logic [SAMPLE_W-1:0]  sample         = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic                 gate_on;
  logic                 window_done;
  logic [HOLE_BITS-1:0] hole_size;
  logic                 defect;

  // averager model state
  bit                   win_open;
  logic [SUM_BITS-1:0]  acc_sum;
  logic [COUNT_W-1:0]   acc_count;
  bit                   defect_q;
  logic [HOLE_BITS-1:0] thresh_q = HOLE_BITS'(SCALE);

  tick_result_t expected_ticks[$];
  tick_result_t head_tick;
  stim_row_t    stim_rows[$];
  logic [SAMPLE_W:0] phase_words[$];

  int  err_count    = 0;
  int  burst_left   = 8;
  int  quiet_cycles = 0;
  bit  hold_req     = 1'b0;

  gated_sample_average_defect_core #(
    .COUNT_BITS (COUNT_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .object_present(object_present),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .gate_on       (gate_on),
    .window_done   (window_done),
    .hole_size     (hole_size),
    .defect        (defect)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic tick_result_t advance_averager(input logic present,
                                                    input logic [SAMPLE_W-1:0] smp);
    tick_result_t   r;
    longint unsigned s;
    longint unsigned q;
    r = '0;
    if (!win_open && present) begin
      win_open  = 1'b1;
      defect_q  = 1'b0;
      acc_sum   = '0;
      acc_count = '0;
    end
    if (win_open) begin
      s = longint'(acc_sum) + longint'(smp);
      acc_sum = (s > SUM_MAX) ? SUM_BITS'(SUM_MAX) : SUM_BITS'(s);
      if (acc_count != '1) acc_count = acc_count + 1'b1;
    end
    if (win_open && !present) begin
      win_open = 1'b0;
      r.done   = 1'b1;
      q = 0;
      if (acc_count != 0) q = (longint'(acc_sum) * SCALE) / longint'(acc_count);
      defect_q = (q > longint'(thresh_q));
      r.hole   = (q > HOLE_MAX) ? HOLE_BITS'(HOLE_MAX) : HOLE_BITS'(q);
    end
    r.gate = win_open;
    r.dfct = defect_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp);
    if (err_count < 40)
      $display("tb: mismatch on %s: got %0d, exp %0d at %0t", what, got, exp, $time);
    err_count++;
  endtask

  task automatic tick_row(input logic p, input logic [SAMPLE_W-1:0] s, input int reps,
                          input bit typed, input tick_result_t want);
    stim_row_t row;
    row.kind    = ROW_TICK;
    row.present = p;
    row.smp     = s;
    row.reps    = reps;
    row.value   = '0;
    row.typed   = typed;
    row.want    = want;
    stim_rows.push_back(row);
  endtask

  task automatic thresh_row(input logic [HOLE_BITS-1:0] v);
    stim_row_t row;
    row       = '{kind: ROW_THRESH, present: 1'b0, smp: '0, reps: 0, value: v,
                  typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endtask

  // offer one word, hold until taken, then maybe close the burst
  task automatic put_word(input logic p, input logic [SAMPLE_W-1:0] s, input bit last,
                          input bit typed, input tick_result_t want);
    tick_result_t r;
    int gap;
    in_valid       <= 1'b1;
    object_present <= p;
    sample         <= s;
    do @(posedge clk); while (!in_ready);
    r = advance_averager(p, s);
    expected_ticks.push_back(typed ? want : r);
    burst_left--;
    gap = 0;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    if (last || gap > 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [HOLE_BITS-1:0] v);
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    thresh_q     = v;
  endtask

  // receiver: runs of steady, random and sparse readiness, plus a long hold on request
  initial begin
    int mode;
    int run;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 2);
      run  = $urandom_range(10, 120);
      repeat (run) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req   = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: begin
              out_ready <= 1'b1;
            end
            1: begin
              out_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_ready <= ($urandom_range(0, 3) == 0);
            end
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected word", 64'(hole_size), 64'd0);
      end else begin
        head_tick = expected_ticks.pop_front();
        if (gate_on !== head_tick.gate)       report_mismatch("gate_on", 64'(gate_on),
                                                              64'(head_tick.gate));
        if (window_done !== head_tick.done)   report_mismatch("window_done", 64'(window_done),
                                                              64'(head_tick.done));
        if (hole_size !== head_tick.hole)     report_mismatch("hole_size", 64'(hole_size),
                                                              64'(head_tick.hole));
        if (defect !== head_tick.dfct)        report_mismatch("defect", 64'(defect),
                                                              64'(head_tick.dfct));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    int k;
    int ph;
    int len;
    int level;
    int style;
    int smp;
    bit last;
    logic [HOLE_BITS-1:0] th;

    // idle ticks after reset, full-scale and all-zero windows at threshold 100
    tick_row(1'b0, 10'd0,    1, 1'b1, {1'b0, 1'b0, 17'd0, 1'b0});
    tick_row(1'b0, 10'd1023, 1, 1'b1, {1'b0, 1'b0, 17'd0, 1'b0});
    tick_row(1'b1, 10'd1023, 1, 1'b1, {1'b1, 1'b0, 17'd0, 1'b0});
    tick_row(1'b0, 10'd1023, 1, 1'b1, {1'b0, 1'b1, 17'd102300, 1'b1});
    tick_row(1'b1, 10'd0,    1, 1'b1, {1'b1, 1'b0, 17'd0, 1'b0});
    tick_row(1'b0, 10'd0,    1, 1'b1, {1'b0, 1'b1, 17'd0, 1'b0});
    tick_row(1'b1, 10'd1,    1, 1'b0, '0);
    tick_row(1'b1, 10'd2,    3, 1'b0, '0);
    tick_row(1'b0, 10'd3,    1, 1'b0, '0);
    // zero threshold: any non-zero mean flags, zero mean does not
    thresh_row(17'd0);
    tick_row(1'b1, 10'd1,    1, 1'b0, '0);
    tick_row(1'b0, 10'd0,    1, 1'b0, '0);
    tick_row(1'b1, 10'd0,    1, 1'b0, '0);
    tick_row(1'b0, 10'd0,    1, 1'b1, {1'b0, 1'b1, 17'd0, 1'b0});
    // top threshold; a long full-scale window lands exactly on it
    thresh_row(17'd102300);
    tick_row(1'b1, 10'd1023, 1,     1'b0, '0);
    tick_row(1'b1, 10'd1023, 300,   1'b0, '0);
    tick_row(1'b0, 10'd1023, 1,     1'b0, '0);
    tick_row(1'b1, 10'd1023, 1, 1'b1, {1'b1, 1'b0, 17'd0, 1'b0});
    tick_row(1'b0, 10'd1023, 1, 1'b1, {1'b0, 1'b1, 17'd102300, 1'b0});
    thresh_row(17'd51150);
    tick_row(1'b0, 10'h2AA,  1, 1'b0, '0);
    tick_row(1'b1, 10'h155,  1, 1'b0, '0);
    tick_row(1'b0, 10'h3FF,  1, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < stim_rows.size(); i++) begin
      if (stim_rows[i].kind == ROW_THRESH) begin
        set_threshold(stim_rows[i].value);
      end else begin
        for (k = 0; k < stim_rows[i].reps; k++) begin
          last = (k == stim_rows[i].reps - 1) &&
                 ((i + 1 == stim_rows.size()) || (stim_rows[i + 1].kind == ROW_THRESH));
          put_word(stim_rows[i].present, stim_rows[i].smp, last,
                   stim_rows[i].typed, stim_rows[i].want);
        end
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)               th = '0;
      else if (ph == PHASES - 1) th = 17'd102300;
      else if ($urandom_range(0, 1) == 1) th = HOLE_BITS'($urandom_range(0, 102300));
      else                       th = HOLE_BITS'($urandom_range(40000, 60000));
      set_threshold(th);
      if (ph == 1 || ph == 4) hold_req = 1'b1;

      phase_words.delete();
      while (phase_words.size() < PHASE_WORDS) begin
        repeat ($urandom_range(0, 2)) phase_words.push_back({1'b0, 10'($urandom_range(0, 1023))});
        if ($urandom_range(0, 9) == 0) begin
          // loose words, object flag at random
          repeat ($urandom_range(1, 8))
            phase_words.push_back({1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023))});
        end else begin
          len   = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
          level = $urandom_range(0, 1023);
          style = $urandom_range(0, 3);
          for (k = 0; k <= len + 1; k++) begin
            case (style)
              0: smp = $urandom_range(0, 1023);
              1: smp = level;
              2: smp = level + $urandom_range(0, 6) - 3;
              default: smp = ($urandom_range(0, 1) == 1) ? 1023 : 0;
            endcase
            if (smp < 0)    smp = 0;
            if (smp > 1023) smp = 1023;
            phase_words.push_back({(k <= len) ? 1'b1 : 1'b0, 10'(smp)});
          end
        end
      end

      for (k = 0; k < phase_words.size(); k++)
        put_word(phase_words[k][SAMPLE_W], phase_words[k][SAMPLE_W-1:0],
                 k == phase_words.size() - 1, 1'b0, '0);
    end

    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
